/* hdl/ffba_pkg.sv */
// Package with the constants, payload types and shared structs of the first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int MEM_BYTES = 1024;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int CNT_W     = $clog2(MEM_BYTES + 1);
    localparam int SIZE_W    = 11;
    localparam int TAG_W     = 8;
    localparam int START_W   = 10;
    localparam int CMP_W     = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_NO_RUN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0] request_size;
        logic [TAG_W-1:0]  owner_tag;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] start_address;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic step;
    } run_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] start;
    } run_stat_t;

endpackage

`default_nettype wire

/* hdl/first_fit_byte_map_allocator_top.sv */
// Top level of the first-fit byte-map allocator: sequencer, free count and result register.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+--------------------------------------
//  req     | in        | req_valid / req_ready | ffba_pkg::req_t (request_size, tag)
//  rsp     | out       | rsp_valid / rsp_ready | ffba_pkg::rsp_t (status, start_address)
//
//  After reset the map is cleared one byte per cycle, with req_ready low.
//  A request larger than the free count is refused with ST_NO_ROOM and skips the scan.
//  Otherwise the map is scanned one byte per cycle through the RAM read port, and a run that
//  fits is then written one byte per cycle with the request's owner tag.
//  The result waits in an output register; a new request is taken while it is held.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_byte_map_allocator_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ffba_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ffba_pkg::rsp_t      rsp
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } state_t;

    state_t            state_reg,      state_next;
    logic [ADDR_W-1:0] clr_addr_reg,   clr_addr_next;
    logic [SIZE_W-1:0] want_reg,       want_next;
    logic [TAG_W-1:0]  tag_reg,        tag_next;
    logic [CNT_W-1:0]  free_reg,       free_next;
    logic [ADDR_W-1:0] scan_addr_reg,  scan_addr_next;
    logic              issued_all_reg, issued_all_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg,  pend_addr_next;
    logic [ADDR_W-1:0] fill_addr_reg,  fill_addr_next;
    logic [CNT_W-1:0]  fill_left_reg,  fill_left_next;
    status_t           status_reg,     status_next;
    logic [ADDR_W-1:0] start_reg,      start_next;
    rsp_t              rsp_reg,        rsp_next;
    logic              rsp_valid_reg,  rsp_valid_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [TAG_W-1:0]  ram_wdata;
    logic [TAG_W-1:0]  ram_rdata;
    run_ctl_t          run_ctl;
    run_stat_t         run_stat;
    logic              accept;
    logic              slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ffba_ram #(
        .DEPTH (MEM_BYTES),
        .WIDTH (TAG_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    ffba_run_unit u_run (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (run_ctl),
        .is_free (ram_rdata == '0),
        .addr    (pend_addr_reg),
        .want    (want_reg),
        .stat    (run_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        want_next       = want_reg;
        tag_next        = tag_reg;
        free_next       = free_reg;
        scan_addr_next  = scan_addr_reg;
        issued_all_next = issued_all_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        fill_addr_next  = fill_addr_reg;
        fill_left_next  = fill_left_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ram_we          = 1'b0;
        ram_waddr       = fill_addr_reg;
        ram_wdata       = tag_reg;
        run_ctl.clear   = 1'b0;
        run_ctl.step    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    want_next       = req.request_size;
                    tag_next        = req.owner_tag;
                    scan_addr_next  = '0;
                    issued_all_next = 1'b0;
                    run_ctl.clear   = 1'b1;
                    start_next      = '0;
                    if (CMP_W'(req.request_size) > CMP_W'(free_reg))
                    begin
                        status_next = ST_NO_ROOM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!issued_all_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = scan_addr_reg;
                    scan_addr_next  = scan_addr_reg + ADDR_W'(1);
                    issued_all_next = (scan_addr_reg == LAST_ADDR);
                end
                if (pend_valid_reg)
                begin
                    run_ctl.step = 1'b1;
                    if (run_stat.hit)
                    begin
                        status_next    = ST_OK;
                        start_next     = run_stat.start;
                        free_next      = free_reg - CNT_W'(want_reg);
                        fill_addr_next = run_stat.start;
                        fill_left_next = CNT_W'(want_reg);
                        state_next     = (want_reg == '0) ? S_DONE : S_FILL;
                    end
                    else if (pend_addr_reg == LAST_ADDR)
                    begin
                        status_next = ST_NO_RUN;
                        state_next  = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                ram_we         = 1'b1;
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                fill_left_next = fill_left_reg - CNT_W'(1);
                if (fill_left_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.start_address = START_W'(start_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            free_reg       <= CNT_W'(MEM_BYTES);
            issued_all_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            free_reg       <= free_next;
            issued_all_reg <= issued_all_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        tag_reg       <= tag_next;
        scan_addr_reg <= scan_addr_next;
        pend_addr_reg <= pend_addr_next;
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        status_reg    <= status_next;
        start_reg     <= start_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

/* hdl/ffba_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/ffba_run_unit.sv */
// Free-run tracker that counts consecutive free bytes and compares the run against the size.
`timescale 1ns / 1ps
`default_nettype none

module ffba_run_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ffba_pkg::run_ctl_t           ctl,
    input  wire logic                         is_free,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  addr,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  want,
    output ffba_pkg::run_stat_t               stat
);
    import ffba_pkg::*;

    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] start_next;
    logic [CNT_W-1:0]  len_plus;
    logic [ADDR_W-1:0] run_start;

    assign len_plus  = len_reg + CNT_W'(1);
    assign run_start = (len_reg == '0) ? addr : start_reg;

    always_comb
    begin
        len_next   = len_reg;
        start_next = start_reg;
        if (ctl.clear)
        begin
            len_next = '0;
        end
        else if (ctl.step)
        begin
            if (is_free)
            begin
                len_next   = len_plus;
                start_next = run_start;
            end
            else
            begin
                len_next = '0;
            end
        end
    end

    assign stat.hit   = ctl.step && !ctl.clear && is_free
                        && (CMP_W'(len_plus) >= CMP_W'(want));
    assign stat.start = run_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

endmodule

`default_nettype wire

/* hdl/ffba_checker.sv */
// Port-level checker for the allocator top level, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module ffba_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire ffba_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire ffba_pkg::rsp_t rsp
);
    import ffba_pkg::*;

    // A held result must not change until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A failed request always reports a zero start address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.start_address == '0)
        else $error("nonzero start address on a failed request");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    // A request larger than the whole memory is refused without a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid
            && (SIZE_W'(MEM_BYTES) < req.request_size)
        |-> ##2 (rsp_valid && (rsp.status == ST_NO_ROOM)))
        else $error("oversized request not refused in time");

endmodule

bind first_fit_byte_map_allocator_top ffba_checker u_ffba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

/* verif/first_fit_byte_map_allocator_top_tb.sv */
// Self-checking testbench for the first-fit byte-map allocator: directed table, then random requests.
`timescale 1ns / 1ps

module first_fit_byte_map_allocator_top_tb;

    import ffba_pkg::*;

    localparam int RANDOM_REQUESTS = 565;
    localparam int LONG_HOLD       = 6000;
    localparam int DRAIN_CYCLES    = 2 * MEM_BYTES + 64;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int PAUSE_AT        = 250;

    typedef struct packed {
        logic [SIZE_W-1:0]  req_bytes;
        logic [TAG_W-1:0]   tag;
        bit                 typed;
        status_t            st;
        logic [START_W-1:0] addr;
    } alloc_case_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   req_valid;
    logic   req_ready;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_ready;
    rsp_t   rsp;

    logic [TAG_W-1:0] owner_bytes [MEM_BYTES];
    logic [CNT_W-1:0] free_bytes;
    rsp_t             pending_allocs [$];
    rsp_t             due;
    int               error_count = 0;
    int               results_seen = 0;
    int               cycle_count = 0;

    alloc_case_t directed_cases [0:15] = '{
        '{11'd0,    8'h01, 1'b1, ST_OK,      10'd0},
        '{11'd2047, 8'hFF, 1'b1, ST_NO_ROOM, 10'd0},
        '{11'd1025, 8'hFE, 1'b1, ST_NO_ROOM, 10'd0},
        '{11'd1,    8'hFF, 1'b1, ST_OK,      10'd0},
        '{11'd3,    8'h01, 1'b1, ST_OK,      10'd1},
        '{11'd4,    8'h00, 1'b1, ST_OK,      10'd4},
        '{11'd2,    8'hAA, 1'b0, ST_OK,      10'd0},
        '{11'd0,    8'h55, 1'b0, ST_OK,      10'd0},
        '{11'd1015, 8'h80, 1'b0, ST_OK,      10'd0},
        '{11'd1024, 8'h7F, 1'b1, ST_NO_ROOM, 10'd0},
        '{11'd300,  8'h2A, 1'b0, ST_OK,      10'd0},
        '{11'd1365, 8'hD5, 1'b1, ST_NO_ROOM, 10'd0},
        '{11'd100,  8'h33, 1'b0, ST_OK,      10'd0},
        '{11'd5,    8'h00, 1'b0, ST_OK,      10'd0},
        '{11'd7,    8'hC3, 1'b0, ST_OK,      10'd0},
        '{11'd0,    8'h00, 1'b0, ST_OK,      10'd0}
    };

    first_fit_byte_map_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rsp_t predict_alloc(req_t r);
        rsp_t res;
        int   run_start;
        int   run_len;
        bit   found;
        res.status        = ST_NO_RUN;
        res.start_address = '0;
        run_start         = 0;
        run_len           = 0;
        found             = 1'b0;
        if (r.request_size > free_bytes)
        begin
            res.status = ST_NO_ROOM;
            return res;
        end
        for (int a = 0; a < MEM_BYTES && !found; a++)
        begin
            if (owner_bytes[a] == '0)
            begin
                if (run_len == 0)
                    run_start = a;
                run_len++;
                if (run_len >= int'(r.request_size))
                    found = 1'b1;
            end
            else
                run_len = 0;
        end
        if (!found)
            return res;
        for (int a = 0; a < int'(r.request_size); a++)
        begin
            if (run_start + a < MEM_BYTES)
                owner_bytes[run_start + a] = r.owner_tag;
        end
        free_bytes        = free_bytes - CNT_W'(r.request_size);
        res.status        = ST_OK;
        res.start_address = START_W'(run_start);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return SIZE_W'($urandom_range(0, 3));
        else if (r < 75)
            return SIZE_W'($urandom_range(4, 15));
        else if (r < 78)
            return SIZE_W'($urandom_range(16, 128));
        else if (r < 82)
            return (free_bytes <= 16) ? SIZE_W'(free_bytes) : SIZE_W'($urandom_range(0, 3));
        else if (r < 92)
            return SIZE_W'(free_bytes + 1);
        else
            return SIZE_W'($urandom_range(MEM_BYTES + 1, (1 << SIZE_W) - 1));
    endfunction

    task automatic issue_alloc(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        @(negedge clk);
        req_valid = 1'b1;
        req       = r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_alloc(r);
        pending_allocs.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic hold_requests(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (pending_allocs.size() == 0)
            begin
                $error("unexpected result: status %0d, start_address %0d",
                       rsp.status, rsp.start_address);
                error_count++;
            end
            else
            begin
                due = pending_allocs.pop_front();
                if (rsp.status !== due.status)
                begin
                    $error("status: expected %0d, got %0d", due.status, rsp.status);
                    error_count++;
                end
                if (rsp.start_address !== due.start_address)
                begin
                    $error("start_address: expected %0d, got %0d",
                           due.start_address, rsp.start_address);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : result_side
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        rsp_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 30)
            begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready = 1'b1;
                if ((results_seen / 40) % 3 != 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : request_side
        req_t next_req;
        rsp_t typed_rsp;
        int   gap;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (int a = 0; a < MEM_BYTES; a++)
            owner_bytes[a] = '0;
        free_bytes = CNT_W'(MEM_BYTES);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_cases[i])
        begin
            next_req.request_size   = directed_cases[i].req_bytes;
            next_req.owner_tag      = directed_cases[i].tag;
            typed_rsp.status        = directed_cases[i].st;
            typed_rsp.start_address = directed_cases[i].addr;
            issue_alloc(next_req, directed_cases[i].typed, typed_rsp);
            hold_requests(pick_gap());
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == PAUSE_AT)
            begin
                hold_requests(1);
                while (pending_allocs.size() != 0)
                    @(posedge clk);
            end
            next_req.request_size = pick_size();
            next_req.owner_tag    = ($urandom_range(0, 99) < 5) ? '0
                                  : TAG_W'($urandom_range(1, 255));
            issue_alloc(next_req, 1'b0, '0);
            gap = ((i / 50) % 3 == 1) ? 0 : pick_gap();
            hold_requests(gap);
        end

        @(negedge clk);
        req_valid = 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_run_unit.sv
hdl/first_fit_byte_map_allocator_top.sv
hdl/ffba_checker.sv
verif/first_fit_byte_map_allocator_top_tb.sv
